// ----- hw/rtl/psic_pkg.sv -----
// ----------------------------------------------------------------------------
// Polyline self-intersection check: shared types and constants
// Status codes, beat layout widths and the probe control word that travels
// down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package psic_pkg;

    localparam int IN_COORD_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_REPEAT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic valid;
        logic hit;
    } probe_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/polyline_self_intersection_check.sv -----
// ----------------------------------------------------------------------------
// Polyline self-intersection check
// Appends candidate vertices to a polyline unless it is full, the vertex
// repeats the last, or its segment crosses or is collinear with a stored one.
//
//  Channel  Dir  Beat contents (lowest bits first)
//  s_       in   tdata: vert_x[7:0], vert_y[15:8]; tuser: start_new
//  m_       out  tdata: accepted[0], status[2:1], vertex_count[7:3]
//
//  One vertex at a time: no new beat is taken until the last one's result has
//  gone into the output register. A beat that needs a segment scan sends a
//  probe walking the cell chain at two stages per cell; a first vertex, a
//  repeat or a beat into a full store skips the scan. A stalled m_ side holds
//  the block before it commits the vertex. Reset empties the polyline.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_self_intersection_check
    import psic_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,   // vert_x, vert_y
    input  wire  [S_TUSER_W-1:0]  s_tuser,   // start_new
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // accepted, status, vertex_count
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         cnt_reg, cnt_eff_reg;
    logic                  res_acc_reg;
    logic [1:0]            res_status_reg;
    logic signed [COORD_BITS-1:0] cand_x_reg, cand_y_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [COORD_BITS-1:0] cx_raw, cy_raw;
    logic [CW-1:0]         cnt_in, cnt_dec, cnt_commit;
    logic [IW-1:0]         last_idx, wr_idx;
    logic signed [COORD_BITS-1:0] last_x, last_y;
    logic                  in_beat, is_full, is_empty, is_repeat, out_free, commit;

    logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];
    probe_ctl_t                   lnk_ctl [MAX_VERTICES+1];
    logic signed [COORD_BITS-1:0] lnk_px  [MAX_VERTICES+1];
    logic signed [COORD_BITS-1:0] lnk_py  [MAX_VERTICES+1];
    logic signed [COORD_BITS-1:0] lnk_qx  [MAX_VERTICES+1];
    logic signed [COORD_BITS-1:0] lnk_qy  [MAX_VERTICES+1];

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_coord
        if (k < IN_COORD_W) begin : g_in
            assign cx_raw[k] = s_tdata[k];
            assign cy_raw[k] = s_tdata[IN_COORD_W+k];
        end else begin : g_pad
            assign cx_raw[k] = 1'b0;
            assign cy_raw[k] = 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        cnt_in    = s_tuser[0] ? '0 : cnt_reg;
        cnt_dec   = cnt_in - CW'(1);
        last_idx  = cnt_dec[IW-1:0];
        last_x    = cell_x[last_idx];
        last_y    = cell_y[last_idx];
        is_full   = (cnt_in >= CW'(MAX_VERTICES));
        is_empty  = (cnt_in == '0);
        is_repeat = (last_x == $signed(cx_raw)) && (last_y == $signed(cy_raw));
    end

    assign lnk_ctl[0].valid = in_beat && !is_full && !is_empty && !is_repeat;
    assign lnk_ctl[0].hit   = 1'b0;
    assign lnk_px[0] = last_x;
    assign lnk_py[0] = last_y;
    assign lnk_qx[0] = $signed(cx_raw);
    assign lnk_qy[0] = $signed(cy_raw);

    assign out_free   = !m_tvalid_reg || m_tready;
    assign commit     = (state_reg == S_DONE) && out_free;
    assign wr_idx     = cnt_eff_reg[IW-1:0];
    assign cnt_commit = res_acc_reg ? cnt_eff_reg + CW'(1) : cnt_eff_reg;

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        logic signed [COORD_BITS-1:0] nx, ny;
        if (i + 1 < MAX_VERTICES) begin : g_nbr
            assign nx = cell_x[i+1];
            assign ny = cell_y[i+1];
        end else begin : g_end
            assign nx = cell_x[i];
            assign ny = cell_y[i];
        end

        psic_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (commit && res_acc_reg && (wr_idx == IW'(i))),
            .wr_x    (cand_x_reg),
            .wr_y    (cand_y_reg),
            .own_x   (cell_x[i]),
            .own_y   (cell_y[i]),
            .nbr_x   (nx),
            .nbr_y   (ny),
            .seg_en  (cnt_eff_reg > CW'(i + 1)),
            .ctl_in  (lnk_ctl[i]),
            .px_in   (lnk_px[i]),
            .py_in   (lnk_py[i]),
            .qx_in   (lnk_qx[i]),
            .qy_in   (lnk_qy[i]),
            .ctl_out (lnk_ctl[i+1]),
            .px_out  (lnk_px[i+1]),
            .py_out  (lnk_py[i+1]),
            .qx_out  (lnk_qx[i+1]),
            .qy_out  (lnk_qy[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_beat) begin
                        cnt_eff_reg <= cnt_in;
                        cand_x_reg  <= $signed(cx_raw);
                        cand_y_reg  <= $signed(cy_raw);
                        res_acc_reg <= 1'b0;
                        if (is_full) begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end else if (is_empty) begin
                            res_acc_reg    <= 1'b1;
                            res_status_reg <= ST_OK;
                            state_reg      <= S_DONE;
                        end else if (is_repeat) begin
                            res_status_reg <= ST_REPEAT;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (lnk_ctl[MAX_VERTICES].valid) begin
                        res_acc_reg    <= !lnk_ctl[MAX_VERTICES].hit;
                        res_status_reg <= lnk_ctl[MAX_VERTICES].hit ? ST_CONFLICT : ST_OK;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        cnt_reg      <= cnt_commit;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {COUNT_OUT_W'(cnt_commit), res_status_reg, res_acc_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/psic_cell.sv -----
// ----------------------------------------------------------------------------
// Polyline check cell
// Holds one stored vertex and tests the probe segment against the segment
// from its vertex to its neighbor's. Two stages: cross-product terms, then
// sign tests; the probe moves on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psic_cell
    import psic_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          wr_en,
    input  wire  signed [COORD_BITS-1:0] wr_x,
    input  wire  signed [COORD_BITS-1:0] wr_y,
    output logic signed [COORD_BITS-1:0] own_x,
    output logic signed [COORD_BITS-1:0] own_y,
    input  wire  signed [COORD_BITS-1:0] nbr_x,
    input  wire  signed [COORD_BITS-1:0] nbr_y,
    input  wire                          seg_en,
    input  probe_ctl_t                   ctl_in,
    input  wire  signed [COORD_BITS-1:0] px_in,
    input  wire  signed [COORD_BITS-1:0] py_in,
    input  wire  signed [COORD_BITS-1:0] qx_in,
    input  wire  signed [COORD_BITS-1:0] qy_in,
    output probe_ctl_t                   ctl_out,
    output logic signed [COORD_BITS-1:0] px_out,
    output logic signed [COORD_BITS-1:0] py_out,
    output logic signed [COORD_BITS-1:0] qx_out,
    output logic signed [COORD_BITS-1:0] qy_out
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [COORD_BITS-1:0] vx_reg, vy_reg;

    probe_ctl_t                   ctl1_reg;
    logic signed [COORD_BITS-1:0] px1_reg, py1_reg, qx1_reg, qy1_reg;
    logic signed [PW-1:0]         pr_reg [8];

    probe_ctl_t                   ctl2_reg;
    logic signed [COORD_BITS-1:0] px2_reg, py2_reg, qx2_reg, qy2_reg;

    logic signed [DW-1:0] ux, uy, sx, sy;
    logic signed [DW-1:0] w1x, w1y, w2x, w2y, w3x, w3y, w4x, w4y;
    logic signed [PW-1:0] pr_next [8];
    logic signed [XW-1:0] d1, d2, d3, d4;
    logic                 col, cross12, cross34, hit_next;

    assign own_x = vx_reg;
    assign own_y = vy_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vx_reg <= wr_x;
            vy_reg <= wr_y;
        end
    end

    always_comb begin
        ux  = DW'(qx_in) - DW'(px_in);
        uy  = DW'(qy_in) - DW'(py_in);
        sx  = DW'(nbr_x) - DW'(vx_reg);
        sy  = DW'(nbr_y) - DW'(vy_reg);
        w1x = DW'(vx_reg) - DW'(px_in);
        w1y = DW'(vy_reg) - DW'(py_in);
        w2x = DW'(nbr_x) - DW'(px_in);
        w2y = DW'(nbr_y) - DW'(py_in);
        w3x = DW'(px_in) - DW'(vx_reg);
        w3y = DW'(py_in) - DW'(vy_reg);
        w4x = DW'(qx_in) - DW'(vx_reg);
        w4y = DW'(qy_in) - DW'(vy_reg);
        pr_next[0] = ux * w1y;
        pr_next[1] = uy * w1x;
        pr_next[2] = ux * w2y;
        pr_next[3] = uy * w2x;
        pr_next[4] = sx * w3y;
        pr_next[5] = sy * w3x;
        pr_next[6] = sx * w4y;
        pr_next[7] = sy * w4x;
    end

    always_comb begin
        d1 = XW'(pr_reg[0]) - XW'(pr_reg[1]);
        d2 = XW'(pr_reg[2]) - XW'(pr_reg[3]);
        d3 = XW'(pr_reg[4]) - XW'(pr_reg[5]);
        d4 = XW'(pr_reg[6]) - XW'(pr_reg[7]);
        col     = (d1 == '0) && (d2 == '0);
        cross12 = (d1 != '0) && (d2 != '0) && (d1[XW-1] != d2[XW-1]);
        cross34 = (d3 != '0) && (d4 != '0) && (d3[XW-1] != d4[XW-1]);
        hit_next = ctl1_reg.hit | (seg_en & (col | (cross12 & cross34)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= ctl_in;
            ctl2_reg.valid <= ctl1_reg.valid;
            ctl2_reg.hit   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        px1_reg <= px_in;
        py1_reg <= py_in;
        qx1_reg <= qx_in;
        qy1_reg <= qy_in;
        for (int k = 0; k < 8; k++) begin
            pr_reg[k] <= pr_next[k];
        end
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;
        qx2_reg <= qx1_reg;
        qy2_reg <= qy1_reg;
    end

    assign ctl_out = ctl2_reg;
    assign px_out  = px2_reg;
    assign py_out  = py2_reg;
    assign qx_out  = qx2_reg;
    assign qy_out  = qy2_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/psic_checker.sv -----
// ----------------------------------------------------------------------------
// Polyline self-intersection check: port checker
// Watches the result beats for consistent verdicts, counts and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module psic_checker
    import psic_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_TDATA_W-1:0] m_tdata
);

    a_accept_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] == ST_OK && m_tdata[7:3] != '0))
        else $error("accepted beat carries bad status or zero count");

    a_reject_code : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] != ST_OK))
        else $error("rejected beat carries ok status");

    a_full_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:1] == ST_FULL) |-> (m_tdata[7:3] == 5'(MAX_VERTICES)))
        else $error("store full reported with wrong count");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind polyline_self_intersection_check psic_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_psic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- bench/polyline_self_intersection_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline self-intersection check testbench
// Streams candidate vertices through the block and predicts every verdict
// with exact integer orientation tests. Directed beats cover the first
// vertex, repeats, crossings, collinear overlap, endpoint touching and a full
// store. Random beats then build convex chains, random walks and scattered
// points under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module polyline_self_intersection_check_tb;
    import psic_pkg::*;

    localparam int MAX_V        = 16;
    localparam int COORD_W      = 8;
    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 2 * MAX_V + 8;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic [1:0]             status;
        logic                   accepted;
    } verdict_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;
    typedef enum {SEQ_CONVEX, SEQ_WALK, SEQ_SCATTER, SEQ_NOISE} seq_kind_t;

    class vertex_scoreboard_t;
        coord_t      vx[MAX_V];
        coord_t      vy[MAX_V];
        int unsigned n_stored;
        verdict_t    due_q[$];
        int          errors;

        function new();
            n_stored = 0;
            errors   = 0;
        endfunction

        function longint turn(int ax, int ay, int bx, int by, int cx, int cy);
            return longint'(bx - ax) * longint'(cy - ay) - longint'(by - ay) * longint'(cx - ax);
        endfunction

        function bit opposite(longint a, longint b);
            return (a > 0 && b < 0) || (a < 0 && b > 0);
        endfunction

        function bit clashes(int px, int py, int qx, int qy,
                             int ax, int ay, int bx, int by);
            longint d1, d2, d3, d4;
            d1 = turn(px, py, qx, qy, ax, ay);
            d2 = turn(px, py, qx, qy, bx, by);
            d3 = turn(ax, ay, bx, by, px, py);
            d4 = turn(ax, ay, bx, by, qx, qy);
            if (d1 == 0 && d2 == 0)
                return 1'b1;
            return opposite(d1, d2) && opposite(d3, d4);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_vertex(bit start_new, coord_t cx, coord_t cy);
            verdict_t v;
            bit       hit;
            v        = '0;
            v.status = ST_OK;
            if (start_new)
                n_stored = 0;
            if (n_stored >= MAX_V) begin
                v.status = ST_FULL;
            end else if (n_stored == 0) begin
                v.accepted = 1'b1;
            end else if (vx[n_stored-1] == cx && vy[n_stored-1] == cy) begin
                v.status = ST_REPEAT;
            end else begin
                hit = 1'b0;
                for (int i = 0; i + 1 < n_stored; i++) begin
                    if (clashes(vx[n_stored-1], vy[n_stored-1], cx, cy,
                                vx[i], vy[i], vx[i+1], vy[i+1]))
                        hit = 1'b1;
                end
                if (hit)
                    v.status = ST_CONFLICT;
                else
                    v.accepted = 1'b1;
            end
            if (v.accepted) begin
                vx[n_stored] = cx;
                vy[n_stored] = cy;
                n_stored++;
            end
            v.count = COUNT_OUT_W'(n_stored);
            due_q = {due_q, v};
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void check_verdict(logic [M_TDATA_W-1:0] beat);
            verdict_t got, want;
            got = beat;
            if (due_q.size() == 0) begin
                flag("unexpected beat, tdata", 8'h00, beat);
                return;
            end
            want = due_q.pop_front();
            if (got.accepted !== want.accepted)
                flag("accepted", want.accepted, got.accepted);
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.count !== want.count)
                flag("vertex_count", want.count, got.count);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // vert_x, vert_y
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // start_new
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // accepted, status, vertex_count

    vertex_scoreboard_t sb = new();
    int                 burst_left = 0;

    polyline_self_intersection_check #(
        .MAX_VERTICES(MAX_V),
        .COORD_BITS  (COORD_W)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, 255));
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v < -128)
            return coord_t'(-128);
        if (v > 127)
            return coord_t'(127);
        return coord_t'(v);
    endfunction

    task automatic offer(bit start_new, coord_t x, coord_t y);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= start_new;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_vertex(start_new, x, y);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_verdict(m_tdata);
    end

    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       cycles;
        bit       held;
        cycles = 0;
        held   = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && cycles > 4000) begin
                // hold off long enough to back up the input side
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                cycles += HOLD_CYCLES;
                held = 1'b1;
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            cycles += span;
            repeat (span) begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
                    default:   m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        seq_kind_t kind;
        int        sent, len, dx, y0, wx, wy, pick;
        bit        swap_xy, flip_x, flip_y, start_flag, paused;
        coord_t    cx, cy, t;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first vertex, repeat, crossing, collinear overlap, endpoint touch
        offer(1'b1, coord_t'(-128), coord_t'(-128));
        offer(1'b0, coord_t'(127), coord_t'(127));
        offer(1'b0, coord_t'(127), coord_t'(127));
        offer(1'b0, coord_t'(-128), coord_t'(127));
        offer(1'b0, coord_t'(127), coord_t'(-128));
        offer(1'b0, coord_t'(0), coord_t'(127));
        offer(1'b0, coord_t'(-128), coord_t'(0));
        offer(1'b0, coord_t'(0), coord_t'(0));
        // fill the store along a convex chain, then overflow it
        for (int i = 0; i <= MAX_V; i++)
            offer(i == 0, coord_t'(-128 + 17 * i), coord_t'(-128 + i * i));
        offer(1'b0, coord_t'(5), coord_t'(5));
        offer(1'b1, coord_t'(127), coord_t'(127));

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                pause_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 4) ? SEQ_CONVEX : (pick < 7) ? SEQ_WALK :
                   (pick < 9) ? SEQ_SCATTER : SEQ_NOISE;
            start_flag = ($urandom_range(0, 9) != 0);
            case (kind)
                SEQ_CONVEX: begin
                    len     = $urandom_range(8, 20);
                    dx      = $urandom_range(1, 14);
                    y0      = $urandom_range(0, 100);
                    swap_xy = 1'($urandom_range(0, 1));
                    flip_x  = 1'($urandom_range(0, 1));
                    flip_y  = 1'($urandom_range(0, 1));
                    for (int i = 0; i < len; i++) begin
                        if (i > 0 && $urandom_range(0, 11) == 0 && sb.n_stored > 0) begin
                            offer(1'b0, sb.vx[sb.n_stored-1], sb.vy[sb.n_stored-1]);
                            sent++;
                        end
                        cx = coord_t'(-128 + dx * i);
                        cy = coord_t'(-128 + y0 + i * (i + 1) / 2);
                        if (swap_xy) begin
                            t  = cx;
                            cx = cy;
                            cy = t;
                        end
                        if (flip_x)
                            cx = ~cx;
                        if (flip_y)
                            cy = ~cy;
                        offer((i == 0) ? start_flag : ($urandom_range(0, 49) == 0), cx, cy);
                        sent++;
                        if ($urandom_range(0, 19) == 0) begin
                            offer(1'b0, any_coord(), any_coord());
                            sent++;
                        end
                    end
                end
                SEQ_WALK: begin
                    len = $urandom_range(3, 20);
                    wx  = int'(any_coord());
                    wy  = int'(any_coord());
                    for (int i = 0; i < len; i++) begin
                        offer((i == 0) ? start_flag : ($urandom_range(0, 49) == 0),
                              coord_t'(wx), coord_t'(wy));
                        sent++;
                        if ($urandom_range(0, 9) != 0) begin
                            wx = int'(clamp_coord(wx + $urandom_range(0, 40) - 20));
                            wy = int'(clamp_coord(wy + $urandom_range(0, 40) - 20));
                        end
                    end
                end
                SEQ_SCATTER: begin
                    len = $urandom_range(2, 8);
                    for (int i = 0; i < len; i++) begin
                        offer((i == 0) ? start_flag : 1'b0, any_coord(), any_coord());
                        sent++;
                    end
                end
                default: begin
                    offer(1'($urandom_range(0, 1)), any_coord(), any_coord());
                    sent++;
                end
            endcase
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/psic_pkg.sv
hw/rtl/psic_cell.sv
hw/rtl/polyline_self_intersection_check.sv
hw/rtl/psic_checker.sv
bench/polyline_self_intersection_check_tb.sv
